### rtl/early_abandon_subsequence_search_core_macros.svh
// Assertion macros for the subsequence search core.
`ifndef EARLY_ABANDON_SUBSEQUENCE_SEARCH_CORE_MACROS_SVH
`define EARLY_ABANDON_SUBSEQUENCE_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define EASS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define EASS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/eass_pkg.sv
// Shared types, widths and codes for the subsequence search core.
`default_nettype none
package eass_pkg;
	localparam int MAX_QUERY_LEN_DEF = 256;

	localparam int OP_W = 2;
	localparam int LEN_W = 9;
	localparam int POS_W = 8;
	localparam int OFF_W = 8;
	localparam int VAL_W = 16;
	localparam int DIFF_W = VAL_W + 1;
	localparam int SQ_W = 32;
	localparam int SUM_W = 48;

	localparam int X_W = LEN_W + 1;
	localparam int RED_W = X_W + LEN_W;
	localparam int RED_SPLIT = 4;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_BIT = 2;
	localparam logic REG_QUERY_LENGTH = 1'b0;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam logic [LEN_W-1:0] LEN_RESET = 9'd256;
	localparam logic [LEN_W-1:0] MIN_LEN = 9'd2;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD   = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_CLEAR  = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_PASS,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             done;
		logic             abandoned;
		logic [SUM_W-1:0] sum;
		logic [LEN_W-1:0] count;
	} acc_status_t;
endpackage
`default_nettype wire

### rtl/eass_accum.sv
// Squared-difference multiply-accumulate with early abandonment.
`default_nettype none
module eass_accum (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 flush,
	input  logic                                 pt_valid,
	input  logic signed [eass_pkg::VAL_W-1:0]    ring_val,
	input  logic signed [eass_pkg::VAL_W-1:0]    query_val,
	input  logic        [eass_pkg::LEN_W-1:0]    m,
	input  logic        [eass_pkg::SUM_W-1:0]    best,
	output eass_pkg::acc_status_t                status
);
	import eass_pkg::*;

	logic                     v_s4;
	logic                     v_s5;
	logic signed [DIFF_W-1:0] d_s4;
	logic        [SQ_W-1:0]   sq_s5;
	logic signed [2*DIFF_W-1:0] prod;
	logic        [SUM_W:0]    add_w;
	logic        [SUM_W-1:0]  sat_sum;
	logic        [SUM_W-1:0]  sum_q;
	logic        [LEN_W-1:0]  cnt_q;
	logic                     fin_q;
	logic                     ab_q;

	assign prod = d_s4 * d_s4;
	assign add_w = {1'b0, sum_q} + (SUM_W + 1)'(sq_s5);
	assign sat_sum = add_w[SUM_W] ? SUM_MAX : add_w[SUM_W-1:0];

	always_ff @(posedge clk) begin
		d_s4 <= DIFF_W'(ring_val) - DIFF_W'(query_val);
		sq_s5 <= prod[SQ_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s4 <= pt_valid && !flush;
			v_s5 <= v_s4 && !flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			fin_q <= 1'b0;
			ab_q <= 1'b0;
		end else if (start) begin
			sum_q <= '0;
			cnt_q <= '0;
			fin_q <= 1'b0;
			ab_q <= 1'b0;
		end else if (v_s5 && !fin_q) begin
			if (sum_q >= best) begin
				fin_q <= 1'b1;
				ab_q <= 1'b1;
			end else begin
				sum_q <= sat_sum;
				cnt_q <= LEN_W'(cnt_q + 1'b1);
				if (LEN_W'(cnt_q + 1'b1) == m) begin
					fin_q <= 1'b1;
				end
			end
		end
	end

	assign status.done = fin_q;
	assign status.abandoned = ab_q;
	assign status.sum = sum_q;
	assign status.count = cnt_q;
endmodule
`default_nettype wire

### rtl/early_abandon_subsequence_search_core.sv
// Top level of the early-abandon subsequence search core.
// A load item stores one query entry (value and window offset) at a slot in comparison order;
// a sample item enters the window ring and, once the window holds query_length samples,
// starts one distance pass; a clear item resets the best distance to all ones. Every item
// returns exactly one result. A pass runs on the single squared-difference multiply-accumulate
// unit that handles one query point per cycle behind a five-stage address, ring read and
// multiply pipeline, and ends early when the pass abandons. After reset the block zeroes
// every entry of the window ring before it takes its first item; configuration writes are
// taken throughout.
`default_nettype none
`include "early_abandon_subsequence_search_core_macros.svh"
module early_abandon_subsequence_search_core #(
	parameter int MAX_QUERY_LEN = eass_pkg::MAX_QUERY_LEN_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic        [eass_pkg::PADDR_W-1:0] paddr,
	input  logic        [eass_pkg::PDATA_W-1:0] pwdata,
	output logic        [eass_pkg::PDATA_W-1:0] prdata,
	output logic                                pready,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic        [eass_pkg::OP_W-1:0]    opcode,
	input  logic        [eass_pkg::POS_W-1:0]   position,
	input  logic signed [eass_pkg::VAL_W-1:0]   query_value,
	input  logic        [eass_pkg::OFF_W-1:0]   window_offset,
	input  logic signed [eass_pkg::VAL_W-1:0]   sample,
	input  logic                                series_start,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic                                window_full,
	output logic        [eass_pkg::SUM_W-1:0]   distance,
	output logic                                abandoned,
	output logic                                improved,
	output logic        [eass_pkg::SUM_W-1:0]   best_distance,
	output logic        [eass_pkg::LEN_W-1:0]   points_checked
);
	import eass_pkg::*;

	localparam int AW = (MAX_QUERY_LEN > 1) ? $clog2(MAX_QUERY_LEN) : 1;
	localparam int FW = $clog2(MAX_QUERY_LEN + 1);
	localparam logic [AW-1:0] CLR_LAST = AW'(MAX_QUERY_LEN - 1);

	state_t state_q;
	state_t state_d;

	logic [AW-1:0]    clr_q;
	logic [LEN_W-1:0] ql_q;
	logic [LEN_W-1:0] m;

	logic [OP_W-1:0]         op_q;
	logic [POS_W-1:0]        pos_q;
	logic signed [VAL_W-1:0] qv_q;
	logic [OFF_W-1:0]        off_q;
	logic signed [VAL_W-1:0] smp_q;
	logic                    start_q;

	logic [LEN_W-1:0] wp_q;
	logic [FW-1:0]    fill_q;
	logic [SUM_W-1:0] best_q;

	logic [LEN_W-1:0] wp_base;
	logic [LEN_W-1:0] wp_inc;
	logic [LEN_W-1:0] wp_next;
	logic [FW-1:0]    fill_base;
	logic [FW-1:0]    fill_next;
	logic             smp_full;
	logic             pos_ok;

	logic signed [VAL_W-1:0] qmem [MAX_QUERY_LEN];
	logic        [OFF_W-1:0] omem [MAX_QUERY_LEN];
	logic signed [VAL_W-1:0] ring [MAX_QUERY_LEN];

	logic                    ring_we;
	logic [AW-1:0]           ring_wa;
	logic signed [VAL_W-1:0] ring_wd;
	logic                    store_we;
	logic                    acc_start;
	logic                    out_load;
	logic                    pass;

	logic [LEN_W-1:0]        iss_q;
	logic                    iss_fire;
	logic                    v_s1;
	logic                    v_s2;
	logic                    v_s3;
	logic signed [VAL_W-1:0] q_s1;
	logic signed [VAL_W-1:0] q_s2;
	logic signed [VAL_W-1:0] q_s3;
	logic [OFF_W-1:0]        off_s1;
	logic [X_W-1:0]          x_s2;
	logic [RED_W-1:0]        red_a;
	logic [RED_W-1:0]        red_b;
	logic [LEN_W-1:0]        idx_s2;
	logic signed [VAL_W-1:0] ring_s3;

	acc_status_t acc_st;

	logic             full_q;
	logic             impr_q;
	logic             rv_q;
	logic             window_full_q;
	logic [SUM_W-1:0] distance_q;
	logic             abandoned_q;
	logic             improved_q;
	logic [SUM_W-1:0] best_distance_q;
	logic [LEN_W-1:0] points_q;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[REG_IDX_BIT] == REG_QUERY_LENGTH) ? PDATA_W'(ql_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ql_q <= LEN_RESET;
		end else if (psel && penable && pwrite && paddr[REG_IDX_BIT] == REG_QUERY_LENGTH) begin
			ql_q <= pwdata[LEN_W-1:0];
		end
	end

	always_comb begin
		if (ql_q < MIN_LEN) begin
			m = MIN_LEN;
		end else if (32'(ql_q) > 32'(MAX_QUERY_LEN)) begin
			m = LEN_W'(MAX_QUERY_LEN);
		end else begin
			m = ql_q;
		end
	end

	// sample bookkeeping
	always_comb begin
		wp_base = start_q ? '0 : wp_q;
		if (wp_base >= m) begin
			wp_base = '0;
		end
		wp_inc = LEN_W'(wp_base + 1'b1);
		wp_next = (wp_inc >= m) ? '0 : wp_inc;
		fill_base = start_q ? '0 : fill_q;
		fill_next = (32'(fill_base) < 32'(MAX_QUERY_LEN)) ? FW'(fill_base + 1'b1) : fill_base;
		smp_full = 32'(fill_next) >= 32'(m);
		pos_ok = 32'(pos_q) < 32'(MAX_QUERY_LEN);
	end

	// sequencer
	assign pass = (state_q == ST_PASS);
	assign iss_fire = pass && (iss_q < m);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		item_ready = 1'b0;
		ring_we = 1'b0;
		ring_wa = clr_q;
		ring_wd = '0;
		store_we = 1'b0;
		acc_start = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ring_we = 1'b1;
				if (clr_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_DONE;
				unique case (op_q)
					OP_LOAD: begin
						store_we = pos_ok;
					end
					OP_SAMPLE: begin
						ring_we = 1'b1;
						ring_wa = AW'(wp_base);
						ring_wd = smp_q;
						if (smp_full) begin
							acc_start = 1'b1;
							state_d = ST_PASS;
						end
					end
					OP_CLEAR: begin
						state_d = ST_DONE;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_PASS: begin
				if (acc_st.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rv_q || result_ready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			op_q <= opcode;
			pos_q <= position;
			qv_q <= query_value;
			off_q <= window_offset;
			smp_q <= sample;
			start_q <= series_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			wp_q <= '0;
			fill_q <= '0;
			best_q <= SUM_MAX;
			full_q <= 1'b0;
			impr_q <= 1'b0;
			iss_q <= '0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= AW'(clr_q + 1'b1);
			end
			if (state_q == ST_EXEC) begin
				full_q <= (op_q == OP_SAMPLE) && smp_full;
				impr_q <= 1'b0;
				iss_q <= '0;
				if (op_q == OP_SAMPLE) begin
					wp_q <= wp_next;
					fill_q <= fill_next;
				end
				if (op_q == OP_CLEAR) begin
					best_q <= SUM_MAX;
				end
			end else if (iss_fire) begin
				iss_q <= LEN_W'(iss_q + 1'b1);
			end
			if (pass && acc_st.done && !acc_st.abandoned && acc_st.sum < best_q) begin
				impr_q <= 1'b1;
				best_q <= acc_st.sum;
			end
		end
	end

	// query and offset stores
	always_ff @(posedge clk) begin
		if (store_we) begin
			qmem[AW'(pos_q)] <= qv_q;
			omem[AW'(pos_q)] <= off_q;
		end
		q_s1 <= qmem[AW'(iss_q)];
		off_s1 <= omem[AW'(iss_q)];
	end

	// window offset modulo m, split over two stages
	always_comb begin
		red_a = RED_W'(wp_q) + RED_W'(off_s1);
		for (int k = X_W - 2; k >= RED_SPLIT; k--) begin
			if (red_a >= (RED_W'(m) << k)) begin
				red_a = red_a - (RED_W'(m) << k);
			end
		end
	end

	always_comb begin
		red_b = RED_W'(x_s2);
		for (int k = RED_SPLIT - 1; k >= 0; k--) begin
			if (red_b >= (RED_W'(m) << k)) begin
				red_b = red_b - (RED_W'(m) << k);
			end
		end
		idx_s2 = LEN_W'(red_b);
	end

	always_ff @(posedge clk) begin
		x_s2 <= X_W'(red_a);
		q_s2 <= q_s1;
		q_s3 <= q_s2;
	end

	// window ring
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring[ring_wa] <= ring_wd;
		end
		ring_s3 <= ring[AW'(idx_s2)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= iss_fire;
			v_s2 <= v_s1 && pass;
			v_s3 <= v_s2 && pass;
		end
	end

	eass_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (acc_start),
		.flush     (!pass),
		.pt_valid  (v_s3),
		.ring_val  (ring_s3),
		.query_val (q_s3),
		.m         (m),
		.best      (best_q),
		.status    (acc_st)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else if (out_load) begin
			rv_q <= 1'b1;
		end else if (result_ready) begin
			rv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			window_full_q <= full_q;
			distance_q <= full_q ? acc_st.sum : '0;
			abandoned_q <= full_q && acc_st.abandoned;
			improved_q <= impr_q;
			best_distance_q <= best_q;
			points_q <= full_q ? acc_st.count : '0;
		end
	end

	assign result_valid = rv_q;
	assign window_full = window_full_q;
	assign distance = distance_q;
	assign abandoned = abandoned_q;
	assign improved = improved_q;
	assign best_distance = best_distance_q;
	assign points_checked = points_q;

	`EASS_ASSERT_IMP(a_improved_is_best, result_valid && improved, !abandoned && window_full && distance == best_distance, "improved result does not match best distance")
	`EASS_ASSERT_IMP(a_no_pass_zero, result_valid && !window_full, distance == '0 && points_checked == '0 && !improved && !abandoned, "result without a pass carries pass data")
	`EASS_ASSERT_IMP(a_abandon_short, result_valid && abandoned, points_checked < m, "abandoned pass checked all points")
	`EASS_ASSERT_NXT(a_best_monotone, !(state_q == ST_EXEC && op_q == OP_CLEAR), best_q <= $past(best_q), "best distance grew without a clear")
endmodule
`default_nettype wire

### tb/early_abandon_subsequence_search_core_test.sv
// Self-checking testbench for the early-abandon subsequence search core.
module early_abandon_subsequence_search_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import eass_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic [PADDR_W-1:0] LEN_ADDR = PADDR_W'(REG_QUERY_LENGTH) << REG_IDX_BIT;
	localparam int NUM_PHASES = 12;
	localparam int HOLD_CYCLES = 1500;

	typedef struct packed {
		logic [OP_W-1:0]         op;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] qv;
		logic [OFF_W-1:0]        off;
		logic signed [VAL_W-1:0] smp;
		logic                    ss;
	} search_item_t;

	typedef struct packed {
		logic             full;
		logic [SUM_W-1:0] sq_dist;
		logic             aband;
		logic             impr;
		logic [SUM_W-1:0] best;
		logic [LEN_W-1:0] checked;
	} search_result_t;

	class match_scoreboard;
		logic signed [VAL_W-1:0] qstore[MAX_QUERY_LEN_DEF];
		logic [OFF_W-1:0]        ostore[MAX_QUERY_LEN_DEF];
		logic signed [VAL_W-1:0] ring[MAX_QUERY_LEN_DEF];
		int unsigned             wp;
		int unsigned             fill;
		logic [SUM_W-1:0]        best;
		logic [LEN_W-1:0]        qlen;
		search_result_t          due[$];
		int                      errors;

		function new();
			for (int k = 0; k < MAX_QUERY_LEN_DEF; k++) begin
				qstore[k] = '0;
				ostore[k] = '0;
				ring[k] = '0;
			end
			wp = 0;
			fill = 0;
			best = SUM_MAX;
			qlen = LEN_RESET;
			errors = 0;
		endfunction

		function int unsigned span();
			if (qlen < MIN_LEN)
				return MIN_LEN;
			if (qlen > MAX_QUERY_LEN_DEF)
				return MAX_QUERY_LEN_DEF;
			return qlen;
		endfunction

		function void note_item(search_item_t it);
			search_result_t r;
			int unsigned    m;
			int unsigned    i;
			int unsigned    idx;
			longint         d;
			logic [63:0]    sum;
			logic [63:0]    sq;
			r = '0;
			m = span();
			case (it.op)
				OP_LOAD: begin
					qstore[it.pos] = it.qv;
					ostore[it.pos] = it.off;
				end
				OP_CLEAR: begin
					best = SUM_MAX;
				end
				OP_SAMPLE: begin
					if (it.ss) begin
						wp = 0;
						fill = 0;
					end
					if (wp >= m)
						wp = 0;
					ring[wp] = it.smp;
					wp++;
					if (wp >= m)
						wp = 0;
					if (fill < MAX_QUERY_LEN_DEF)
						fill++;
					if (fill >= m) begin
						sum = '0;
						i = 0;
						r.full = 1'b1;
						while (i < m && sum < {16'b0, best}) begin
							idx = (wp + ostore[i]) % m;
							d = longint'(ring[idx]) - longint'(qstore[i]);
							sq = 64'(d * d);
							sum = (sum > {16'b0, SUM_MAX} - sq) ? {16'b0, SUM_MAX} : sum + sq;
							i++;
						end
						r.sq_dist = sum[SUM_W-1:0];
						r.checked = LEN_W'(i);
						if (i < m) begin
							r.aband = 1'b1;
						end else if (sum < {16'b0, best}) begin
							best = sum[SUM_W-1:0];
							r.impr = 1'b1;
						end
					end
				end
				default: ;
			endcase
			r.best = best;
			due.push_back(r);
		endfunction

		function void report(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(search_result_t got);
			search_result_t want;
			if (due.size() == 0) begin
				errors++;
				$display("%0t: result with no transaction outstanding, actual %p", $time, got);
				return;
			end
			want = due.pop_front();
			report("window_full", want.full, got.full);
			report("distance", want.sq_dist, got.sq_dist);
			report("abandoned", want.aband, got.aband);
			report("improved", want.impr, got.impr);
			report("best_distance", want.best, got.best);
			report("points_checked", want.checked, got.checked);
		endfunction

		function int pending();
			return due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic item_valid = 1'b0;
	logic item_ready;
	logic [OP_W-1:0] opcode = '0;
	logic [POS_W-1:0] position = '0;
	logic signed [VAL_W-1:0] query_value = '0;
	logic [OFF_W-1:0] window_offset = '0;
	logic signed [VAL_W-1:0] sample = '0;
	logic series_start = 1'b0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic window_full;
	logic [SUM_W-1:0] distance;
	logic abandoned;
	logic improved;
	logic [SUM_W-1:0] best_distance;
	logic [LEN_W-1:0] points_checked;

	match_scoreboard sb = new();
	int burst_left = 0;
	logic hold_req = 1'b0;
	int phase_len[NUM_PHASES] = '{2, 0, 1, 3, 8, 17, 64, 511, 256, 300, 5, 2};
	int phase_items[NUM_PHASES] = '{300, 150, 150, 200, 250, 250, 200, 60, 80, 40, 200, 120};

	early_abandon_subsequence_search_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.opcode        (opcode),
		.position      (position),
		.query_value   (query_value),
		.window_offset (window_offset),
		.sample        (sample),
		.series_start  (series_start),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.window_full   (window_full),
		.distance      (distance),
		.abandoned     (abandoned),
		.improved      (improved),
		.best_distance (best_distance),
		.points_checked(points_checked)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result({window_full, distance, abandoned, improved, best_distance,
				points_checked});
	end

	int rx_mode = 0;
	int rx_left = 0;
	int rx_cycle = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	always @(posedge clk) begin
		rx_cycle++;
		if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(64, 512);
			end
			rx_left--;
			case (rx_mode)
				0: result_ready <= 1'b1;
				1: result_ready <= 1'($urandom_range(0, 1));
				2: result_ready <= (rx_cycle % 4 == 0);
				default: result_ready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	function automatic search_item_t noise_item();
		search_item_t it;
		it = search_item_t'({$urandom, $urandom});
		return it;
	endfunction

	task automatic send_item(search_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_valid <= 1'b1;
		opcode <= it.op;
		position <= it.pos;
		query_value <= it.qv;
		window_offset <= it.off;
		sample <= it.smp;
		series_start <= it.ss;
		do @(posedge clk); while (!item_ready);
		sb.note_item(it);
	endtask

	task automatic load_entry(int pos, logic signed [VAL_W-1:0] qv, logic [OFF_W-1:0] off);
		search_item_t it;
		it = noise_item();
		it.op = OP_LOAD;
		it.pos = POS_W'(pos);
		it.qv = qv;
		it.off = off;
		send_item(it);
	endtask

	task automatic feed_sample(logic signed [VAL_W-1:0] smp, logic ss);
		search_item_t it;
		it = noise_item();
		it.op = OP_SAMPLE;
		it.smp = smp;
		it.ss = ss;
		send_item(it);
	endtask

	task automatic send_op(logic [OP_W-1:0] op);
		search_item_t it;
		it = noise_item();
		it.op = op;
		send_item(it);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_query_length(logic [LEN_W-1:0] v);
		logic [PDATA_W-1:0] word;
		word = {$urandom};
		word[LEN_W-1:0] = v;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LEN_ADDR;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.qlen = v;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== PDATA_W'(v)) begin
			sb.errors++;
			$display("%0t: query_length readback mismatch, expected %0d, actual %0d",
				$time, v, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		#20_000_000;
		$display("early_abandon_subsequence_search_core verification failed");
		$finish;
	end

	initial begin
		search_item_t it;
		int unsigned  m;
		int unsigned  k;
		int           pick;
		int           v;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < MAX_QUERY_LEN_DEF; p++)
			load_entry(p, VAL_W'($urandom), OFF_W'($urandom));
		drain();
		set_query_length(MIN_LEN);

		load_entry(0, 16'sh8000, 8'd0);
		load_entry(1, 16'sh7FFF, 8'd255);
		load_entry(255, 16'sh7FFF, 8'd255);
		send_op(OP_UNUSED);
		feed_sample(16'sh7FFF, 1'b1);
		feed_sample(16'sh8000, 1'b0);
		feed_sample(16'sh7FFF, 1'b0);
		feed_sample(16'sh8000, 1'b0);
		send_op(OP_CLEAR);
		feed_sample(16'sh0000, 1'b0);
		load_entry(0, 16'sh0000, 8'd0);
		load_entry(1, 16'sh0000, 8'd1);
		feed_sample(16'sh0000, 1'b1);
		feed_sample(16'sh0000, 1'b0);
		feed_sample(16'sh0064, 1'b0);
		feed_sample(16'sh0000, 1'b0);
		send_op(OP_CLEAR);
		feed_sample(16'sh0000, 1'b0);
		feed_sample(16'sh0005, 1'b1);
		send_op(OP_UNUSED);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			set_query_length(LEN_W'(phase_len[ph]));
			if (ph == 0)
				hold_req <= 1'b1;
			for (int n = 0; n < phase_items[ph]; n++) begin
				it = noise_item();
				m = sb.span();
				pick = $urandom_range(0, 99);
				if (pick < 85) begin
					it.op = OP_SAMPLE;
					it.ss = ($urandom_range(0, 2 * m + 3) == 0) || ($urandom_range(0, 49) == 0);
					k = $urandom_range(0, m - 1);
					v = $urandom_range(0, 99);
					if (v < 55)
						it.smp = sb.qstore[k] + VAL_W'($urandom_range(0, 32)) - VAL_W'(16);
					else if (v < 80)
						it.smp = it.smp;
					else if (v < 90)
						it.smp = v[0] ? 16'sh7FFF : 16'sh8000;
					else
						it.smp = '0;
				end else if (pick < 93) begin
					it.op = OP_LOAD;
					if ($urandom_range(0, 3) != 0)
						it.pos = POS_W'($urandom_range(0, m - 1));
				end else if (pick < 96) begin
					it.op = OP_CLEAR;
				end else begin
					it.op = OP_UNUSED;
				end
				send_item(it);
			end
		end

		drain();
		repeat (300) @(posedge clk);
		if (sb.errors == 0)
			$display("early_abandon_subsequence_search_core verification clean");
		else
			$display("early_abandon_subsequence_search_core verification failed");
		$finish;
	end
endmodule
